/* hdl/clx_pkg.sv */
// ----------------------------------------------------------------------------
// clx_pkg
// Shared types and constants for the c subset lexer: token kinds, the token
// record handed from the scanner to the token queue, and sizing constants.
// ----------------------------------------------------------------------------
package clx_pkg;

    // source size limit and the width of byte positions and token lengths
    localparam int unsigned MAX_SOURCE_BYTES = 65536;
    localparam int          POS_W            = $clog2(MAX_SOURCE_BYTES + 1);

    // saturation points of the reported offset and length
    localparam int unsigned START_MAX = 65535;
    localparam int unsigned LEN_MAX   = 65536;

    // keyword table, each entry right justified and zero padded
    localparam int KW_MAX_LEN   = 6;
    localparam int KW_W         = 8 * KW_MAX_LEN;
    localparam int NUM_KEYWORDS = 9;
    localparam logic [KW_W-1:0] KEYWORDS [NUM_KEYWORDS] = '{
        "auto", "extern", "return", "if", "else", "while", "switch", "case", "goto"
    };

    // token queue sizing
    localparam int PUSH_MAX    = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        KIND_END        = 6'd0,
        KIND_ERROR      = 6'd1,
        KIND_AUTO       = 6'd2,
        KIND_EXTERN     = 6'd3,
        KIND_RETURN     = 6'd4,
        KIND_IF         = 6'd5,
        KIND_ELSE       = 6'd6,
        KIND_WHILE      = 6'd7,
        KIND_SWITCH     = 6'd8,
        KIND_CASE       = 6'd9,
        KIND_GOTO       = 6'd10,
        KIND_IDENT      = 6'd11,
        KIND_INT        = 6'd12,
        KIND_LPAREN     = 6'd13,
        KIND_RPAREN     = 6'd14,
        KIND_LBRACE     = 6'd15,
        KIND_RBRACE     = 6'd16,
        KIND_LBRACK     = 6'd17,
        KIND_RBRACK     = 6'd18,
        KIND_SEMI       = 6'd19,
        KIND_QUEST      = 6'd20,
        KIND_COLON      = 6'd21,
        KIND_COMMA      = 6'd22,
        KIND_EQ         = 6'd23,
        KIND_ASSIGN     = 6'd24,
        KIND_NE         = 6'd25,
        KIND_NOT        = 6'd26,
        KIND_LE         = 6'd27,
        KIND_SHL_ASSIGN = 6'd28,
        KIND_SHL        = 6'd29,
        KIND_LT         = 6'd30,
        KIND_GE         = 6'd31,
        KIND_SHR_ASSIGN = 6'd32,
        KIND_SHR        = 6'd33,
        KIND_GT         = 6'd34,
        KIND_INC        = 6'd35,
        KIND_ADD_ASSIGN = 6'd36,
        KIND_PLUS       = 6'd37,
        KIND_DEC        = 6'd38,
        KIND_SUB_ASSIGN = 6'd39,
        KIND_MINUS      = 6'd40,
        KIND_MUL_ASSIGN = 6'd41,
        KIND_STAR       = 6'd42,
        KIND_DIV_ASSIGN = 6'd43,
        KIND_SLASH      = 6'd44,
        KIND_MOD_ASSIGN = 6'd45,
        KIND_PERCENT    = 6'd46,
        KIND_AND        = 6'd47,
        KIND_AND_ASSIGN = 6'd48,
        KIND_OR         = 6'd49,
        KIND_OR_ASSIGN  = 6'd50
    } clx_kind_t;

    typedef struct packed {
        logic        last;
        logic [16:0] len;
        logic [15:0] start;
        clx_kind_t   kind;
    } clx_token_t;

    // tokens produced by one source byte, in order, count of them valid
    typedef struct packed {
        logic [1:0]                  count;
        clx_token_t [PUSH_MAX-1:0]   tok;
    } clx_push_t;

endpackage

/* hdl/clx_front.sv */
// ----------------------------------------------------------------------------
// clx_front
// Scanner front end: takes one source byte per transfer, tracks the pending
// token and writes up to three finished tokens per byte into the token queue.
// ----------------------------------------------------------------------------
module clx_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                room,
    output clx_pkg::clx_push_t  push
);

    localparam int POS_W = clx_pkg::POS_W;
    localparam int KW_W  = clx_pkg::KW_W;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_OPER,
        MODE_COMMENT,
        MODE_HALT
    } mode_t;

    typedef struct packed {
        logic                valid;
        clx_pkg::clx_token_t tok;
    } emit_t;

    mode_t             mode_reg, mode_next;
    logic [7:0]        held_reg, held_next;
    logic [1:0]        stage_reg, stage_next;
    logic [KW_W-1:0]   window_reg, window_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    clx_pkg::clx_push_t push_next;

    logic                          in_fire;
    logic                          restart;
    emit_t                         flushed;
    logic [2:0]                    n;
    clx_pkg::clx_token_t [2:0]     slot;
    clx_pkg::clx_kind_t            k_single;
    clx_pkg::clx_kind_t            k_lone;
    clx_pkg::clx_kind_t            k_pair;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic clx_pkg::clx_kind_t single_kind(input logic [7:0] c);
        clx_pkg::clx_kind_t k;
        case (c)
            "(":     k = clx_pkg::KIND_LPAREN;
            ")":     k = clx_pkg::KIND_RPAREN;
            "{":     k = clx_pkg::KIND_LBRACE;
            "}":     k = clx_pkg::KIND_RBRACE;
            "[":     k = clx_pkg::KIND_LBRACK;
            "]":     k = clx_pkg::KIND_RBRACK;
            ";":     k = clx_pkg::KIND_SEMI;
            "?":     k = clx_pkg::KIND_QUEST;
            ":":     k = clx_pkg::KIND_COLON;
            ",":     k = clx_pkg::KIND_COMMA;
            default: k = clx_pkg::KIND_END;
        endcase
        return k;
    endfunction

    function automatic clx_pkg::clx_kind_t lone_op_kind(input logic [7:0] c);
        clx_pkg::clx_kind_t k;
        case (c)
            "=":     k = clx_pkg::KIND_ASSIGN;
            "!":     k = clx_pkg::KIND_NOT;
            "<":     k = clx_pkg::KIND_LT;
            ">":     k = clx_pkg::KIND_GT;
            "+":     k = clx_pkg::KIND_PLUS;
            "-":     k = clx_pkg::KIND_MINUS;
            "*":     k = clx_pkg::KIND_STAR;
            "/":     k = clx_pkg::KIND_SLASH;
            "%":     k = clx_pkg::KIND_PERCENT;
            "&":     k = clx_pkg::KIND_AND;
            "|":     k = clx_pkg::KIND_OR;
            default: k = clx_pkg::KIND_END;
        endcase
        return k;
    endfunction

    function automatic clx_pkg::clx_kind_t pair_kind(input logic [7:0] h, input logic [7:0] c);
        clx_pkg::clx_kind_t k;
        k = clx_pkg::KIND_END;
        case (h)
            "=": if (c == "=") k = clx_pkg::KIND_EQ;
            "!": if (c == "=") k = clx_pkg::KIND_NE;
            "<": if (c == "=") k = clx_pkg::KIND_LE;
            ">": if (c == "=") k = clx_pkg::KIND_GE;
            "+": k = (c == "+") ? clx_pkg::KIND_INC :
                     ((c == "=") ? clx_pkg::KIND_ADD_ASSIGN : clx_pkg::KIND_END);
            "-": k = (c == "-") ? clx_pkg::KIND_DEC :
                     ((c == "=") ? clx_pkg::KIND_SUB_ASSIGN : clx_pkg::KIND_END);
            "*": if (c == "=") k = clx_pkg::KIND_MUL_ASSIGN;
            "/": if (c == "=") k = clx_pkg::KIND_DIV_ASSIGN;
            "%": if (c == "=") k = clx_pkg::KIND_MOD_ASSIGN;
            "&": k = (c == "&") ? clx_pkg::KIND_AND :
                     ((c == "=") ? clx_pkg::KIND_AND_ASSIGN : clx_pkg::KIND_END);
            "|": k = (c == "|") ? clx_pkg::KIND_OR :
                     ((c == "=") ? clx_pkg::KIND_OR_ASSIGN : clx_pkg::KIND_END);
            default: k = clx_pkg::KIND_END;
        endcase
        return k;
    endfunction

    function automatic clx_pkg::clx_kind_t ident_kind(input logic [KW_W-1:0] window,
                                                      input logic [POS_W-1:0] len);
        clx_pkg::clx_kind_t k;
        k = clx_pkg::KIND_IDENT;
        if (len <= POS_W'(clx_pkg::KW_MAX_LEN)) begin
            for (int i = 0; i < clx_pkg::NUM_KEYWORDS; i++) begin
                if (window == clx_pkg::KEYWORDS[i]) begin
                    k = clx_pkg::clx_kind_t'(clx_pkg::KIND_AUTO + 6'(i));
                end
            end
        end
        return k;
    endfunction

    function automatic clx_pkg::clx_token_t make_tok(input clx_pkg::clx_kind_t kind,
                                                     input logic [POS_W-1:0] start,
                                                     input logic [POS_W-1:0] len,
                                                     input logic last);
        logic [31:0]         s32;
        logic [31:0]         l32;
        clx_pkg::clx_token_t t;
        s32 = 32'(start);
        l32 = 32'(len);
        t.kind  = kind;
        t.start = (s32 > 32'(clx_pkg::START_MAX)) ? 16'(clx_pkg::START_MAX) : s32[15:0];
        t.len   = (l32 > 32'(clx_pkg::LEN_MAX)) ? 17'(clx_pkg::LEN_MAX) : l32[16:0];
        t.last  = last;
        return t;
    endfunction

    // token left pending by the given state, if any
    function automatic emit_t flush_tok(input mode_t m, input logic [7:0] held,
                                        input logic [1:0] stage,
                                        input logic [POS_W-1:0] start,
                                        input logic [POS_W-1:0] len,
                                        input logic [KW_W-1:0] window);
        emit_t e;
        e.valid = 1'b0;
        e.tok   = make_tok(clx_pkg::KIND_END, '0, '0, 1'b0);
        case (m)
            MODE_IDENT: begin
                e.valid = 1'b1;
                e.tok   = make_tok(ident_kind(window, len), start, len, 1'b0);
            end
            MODE_NUM: begin
                e.valid = 1'b1;
                e.tok   = make_tok(clx_pkg::KIND_INT, start, len, 1'b0);
            end
            MODE_OPER: begin
                e.valid = 1'b1;
                if (stage == 2'd2) begin
                    e.tok = make_tok((held == "<") ? clx_pkg::KIND_SHL : clx_pkg::KIND_SHR,
                                     start, POS_W'(2), 1'b0);
                end else begin
                    e.tok = make_tok(lone_op_kind(held), start, POS_W'(1), 1'b0);
                end
            end
            default: e.valid = 1'b0;
        endcase
        return e;
    endfunction

    assign s_tready = room;
    assign in_fire  = s_tvalid & room;
    assign k_single = single_kind(s_tdata);
    assign k_lone   = lone_op_kind(s_tdata);
    assign k_pair   = pair_kind(held_reg, s_tdata);

    always_comb begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        stage_next  = stage_reg;
        window_next = window_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        restart     = 1'b0;
        n           = '0;
        slot        = '0;
        flushed     = '0;

        if (in_fire) begin
            if (mode_reg != MODE_HALT) begin
                if (pos_reg >= POS_W'(clx_pkg::MAX_SOURCE_BYTES)) begin
                    // size limit reached: close the pending token, then error
                    flushed = flush_tok(mode_reg, held_reg, stage_reg, start_reg,
                                        count_reg, window_reg);
                    if (flushed.valid) begin
                        slot[n[1:0]] = flushed.tok;
                        n = n + 3'd1;
                    end
                    slot[n[1:0]] = make_tok(clx_pkg::KIND_ERROR, pos_reg, '0, 1'b0);
                    n = n + 3'd1;
                    mode_next  = MODE_HALT;
                    held_next  = '0;
                    stage_next = '0;
                end else begin
                    case (mode_reg)
                        MODE_IDENT: begin
                            if (is_alpha(s_tdata) || is_digit(s_tdata) || s_tdata == "_") begin
                                count_next  = count_reg + POS_W'(1);
                                window_next = {window_reg[KW_W-9:0], s_tdata};
                            end else begin
                                restart = 1'b1;
                            end
                        end
                        MODE_NUM: begin
                            if (is_digit(s_tdata)) begin
                                count_next = count_reg + POS_W'(1);
                            end else begin
                                restart = 1'b1;
                            end
                        end
                        MODE_COMMENT: begin
                            if (held_reg == "*" && s_tdata == "/") begin
                                mode_next = MODE_IDLE;
                                held_next = '0;
                            end else begin
                                held_next = (s_tdata == "*") ? 8'("*") : 8'd0;
                            end
                        end
                        MODE_OPER: begin
                            if (stage_reg == 2'd2) begin
                                if (s_tdata == "=") begin
                                    slot[n[1:0]] = make_tok((held_reg == "<") ?
                                                            clx_pkg::KIND_SHL_ASSIGN :
                                                            clx_pkg::KIND_SHR_ASSIGN,
                                                            start_reg, POS_W'(3), 1'b0);
                                    n = n + 3'd1;
                                    mode_next  = MODE_IDLE;
                                    held_next  = '0;
                                    stage_next = '0;
                                end else begin
                                    restart = 1'b1;
                                end
                            end else if (held_reg == "/" && s_tdata == "*") begin
                                mode_next  = MODE_COMMENT;
                                held_next  = '0;
                                stage_next = '0;
                            end else if ((held_reg == "<" || held_reg == ">") &&
                                         s_tdata == held_reg) begin
                                stage_next = 2'd2;
                            end else if (k_pair != clx_pkg::KIND_END) begin
                                slot[n[1:0]] = make_tok(k_pair, start_reg, POS_W'(2), 1'b0);
                                n = n + 3'd1;
                                mode_next  = MODE_IDLE;
                                held_next  = '0;
                                stage_next = '0;
                            end else begin
                                restart = 1'b1;
                            end
                        end
                        MODE_IDLE: restart = 1'b1;
                        default:   restart = 1'b0;
                    endcase

                    if (restart) begin
                        flushed = flush_tok(mode_reg, held_reg, stage_reg, start_reg,
                                            count_reg, window_reg);
                        if (flushed.valid) begin
                            slot[n[1:0]] = flushed.tok;
                            n = n + 3'd1;
                        end
                        mode_next  = MODE_IDLE;
                        held_next  = '0;
                        stage_next = '0;
                        // classify the byte as the first of a new token
                        if (is_alpha(s_tdata)) begin
                            mode_next   = MODE_IDENT;
                            start_next  = pos_reg;
                            count_next  = POS_W'(1);
                            window_next = KW_W'(s_tdata);
                        end else if (is_digit(s_tdata)) begin
                            mode_next  = MODE_NUM;
                            start_next = pos_reg;
                            count_next = POS_W'(1);
                        end else if (is_space(s_tdata)) begin
                            mode_next = MODE_IDLE;
                        end else if (k_single != clx_pkg::KIND_END) begin
                            slot[n[1:0]] = make_tok(k_single, pos_reg, POS_W'(1), 1'b0);
                            n = n + 3'd1;
                        end else if (k_lone != clx_pkg::KIND_END) begin
                            mode_next  = MODE_OPER;
                            held_next  = s_tdata;
                            stage_next = 2'd1;
                            start_next = pos_reg;
                        end else begin
                            slot[n[1:0]] = make_tok(clx_pkg::KIND_ERROR, pos_reg,
                                                    POS_W'(1), 1'b0);
                            n = n + 3'd1;
                            mode_next = MODE_HALT;
                        end
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
            end

            if (s_tlast) begin
                flushed = flush_tok(mode_next, held_next, stage_next, start_next,
                                    count_next, window_next);
                if (flushed.valid) begin
                    slot[n[1:0]] = flushed.tok;
                    n = n + 3'd1;
                end
                slot[n[1:0]] = make_tok(clx_pkg::KIND_END, pos_next, '0, 1'b1);
                n = n + 3'd1;
                // the next byte starts a fresh stream
                mode_next   = MODE_IDLE;
                held_next   = '0;
                stage_next  = '0;
                window_next = '0;
                start_next  = '0;
                count_next  = '0;
                pos_next    = '0;
            end
        end

        push_next.count = n[1:0];
        push_next.tok   = slot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            held_reg   <= '0;
            stage_reg  <= '0;
            window_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            push       <= '0;
        end else begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            stage_reg  <= stage_next;
            window_reg <= window_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            push       <= push_next;
        end
    end

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_tlast && mode_reg == MODE_HALT) |=> push.count == 2'd0)
        else $error("halted scanner produced a token");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> push.count == 2'd0)
        else $error("token produced without a byte transfer");

    a_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tlast) |=> (push.count != 2'd0 && push.tok[push.count - 2'd1].last))
        else $error("final byte did not close the stream with an end token");

endmodule

/* hdl/clx_queue.sv */
// ----------------------------------------------------------------------------
// clx_queue
// Token queue and result side: holds finished tokens, takes up to three per
// cycle from the scanner and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module clx_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  clx_pkg::clx_push_t  push,
    output logic                room,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // token_kind[5:0], start_offset[21:6],
                                           // token_length[38:22], zero[39]
    output logic                m_tlast
);

    localparam int DEPTH = clx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = clx_pkg::QPTR_W;

    clx_pkg::clx_token_t mem [DEPTH];
    clx_pkg::clx_token_t head;

    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             pop;

    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = count_reg != '0;
    assign head     = mem[rd_reg];
    assign m_tdata  = {1'b0, head.len, head.start, head.kind};
    assign m_tlast  = head.last;
    // room for a worst case byte on top of the tokens already on their way in
    assign room     = (count_reg + (PTR_W + 1)'(push.count)) <=
                      (PTR_W + 1)'(DEPTH - clx_pkg::PUSH_MAX);

    always_comb begin
        wr_next    = wr_reg + PTR_W'(push.count);
        rd_next    = rd_reg + PTR_W'(pop);
        count_next = count_reg + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < clx_pkg::PUSH_MAX; i++) begin
            if (2'(i) < push.count) begin
                mem[PTR_W'(wr_reg + PTR_W'(i))] <= push.tok[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W + 1)'(DEPTH))
        else $error("token queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> $past(room))
        else $error("tokens written without room in the queue");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pop && push.count == 2'd0) |=> $stable(count_reg) && $stable(rd_reg))
        else $error("queue level moved without a transfer");

endmodule

/* hdl/c_subset_lexer.sv */
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming lexer for a small c subset: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Input channel s_*: one source byte per transfer in s_tdata, s_tlast on the
// final byte of the source. Output channel m_*: one token per transfer with
// kind, start offset and length in m_tdata; m_tlast marks the end token that
// closes every stream, after which the next byte begins a new stream.
// The scanner handles one byte per cycle and registers the tokens that byte
// completes (zero to three); an eight entry token queue then stores them, so
// a token reaches m_* through the scanner's push register and then the queue
// entry that holds it.
// Throughput is one byte per cycle. s_tready drops while the queue, counting
// the tokens still on their way in, has fewer than three free entries, so
// the output side (one token per cycle) sets the pace when tokens arrive
// faster than they are taken.
// An invalid byte or a source longer than the size limit yields an error
// token; later bytes are dropped until the final byte, which still yields
// the end token. A stalled receiver just holds m_* and backs up the queue.
// Reset (aresetn low, synchronous) empties the queue and restarts the stream.
// ----------------------------------------------------------------------------
module c_subset_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // source_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // token_kind[5:0], start_offset[21:6],
                                    // token_length[38:22], zero[39]
    output logic        m_tlast
);

    clx_pkg::clx_push_t push;
    logic               room;

    clx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .room     (room),
        .push     (push)
    );

    clx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
